// File: rtl/nsc_pkg.sv
// package for the nfa subset construction unit
// types, constants and state codes shared by the cell chain and the top level
package nsc_pkg;

    localparam int NFA_STATES_MAX = 16;
    localparam int SYMBOLS_MAX    = 4;
    localparam int DFA_STATES_MAX = 64;
    localparam int MASK_W         = 16;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;
    localparam int SYM_W          = 2;
    localparam int SRC_W          = 4;

    localparam logic [1:0] REG_NFA_STATES = 2'd0;
    localparam logic [1:0] REG_SYMBOLS    = 2'd1;
    localparam logic [1:0] REG_ACCEPT     = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_GATHER,
        ST_SEARCH,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    // broadcast from sequencer into the cell chain
    typedef struct packed {
        logic              clear;
        logic              shift;
        logic [MASK_W-1:0] key;
    } t_chain_ctl;

endpackage

// File: rtl/nsc_cell.sv
// one cell of the subset search chain
// holds one stored subset and compares it with the broadcast key; uses nsc_pkg
module nsc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nsc_pkg::t_chain_ctl        i_ctl,
    input  logic                       i_valid,
    input  logic [nsc_pkg::MASK_W-1:0] i_mask,
    output logic                       o_valid,
    output logic [nsc_pkg::MASK_W-1:0] o_mask,
    output logic                       o_hit
);
    import nsc_pkg::*;

    logic              r_valid;
    logic [MASK_W-1:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_mask <= i_mask;
        end
    end

    assign o_valid = r_valid;
    assign o_mask  = r_mask;
    assign o_hit   = r_valid && (r_mask == i_ctl.key);
endmodule

// File: rtl/nsc_chain.sv
// row of search cells; new subsets shift in at the head
// match position gives index as count-1-position; uses nsc_pkg and nsc_cell
module nsc_chain #(
    parameter int DFA_MAX = nsc_pkg::DFA_STATES_MAX
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nsc_pkg::t_chain_ctl        i_ctl,
    input  logic [nsc_pkg::MASK_W-1:0] i_new_mask,
    output logic                       o_hit,
    output logic [$clog2(DFA_MAX)-1:0] o_hit_pos
);
    import nsc_pkg::*;

    localparam int POS_W = $clog2(DFA_MAX);

    logic [DFA_MAX:0]  w_valid;
    logic [MASK_W-1:0] w_mask [DFA_MAX+1];
    logic [DFA_MAX-1:0] w_hit;

    assign w_valid[0] = 1'b1;
    assign w_mask[0]  = i_new_mask;

    for (genvar g = 0; g < DFA_MAX; g++) begin : g_cell
        nsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_valid (w_valid[g]),
            .i_mask  (w_mask[g]),
            .o_valid (w_valid[g+1]),
            .o_mask  (w_mask[g+1]),
            .o_hit   (w_hit[g])
        );
    end

    // subsets are distinct, so at most one cell hits
    always_comb begin
        o_hit_pos = '0;
        for (int k = 0; k < DFA_MAX; k++) begin
            if (w_hit[k]) o_hit_pos |= POS_W'(k);
        end
        o_hit = |w_hit;
    end
endmodule

// File: rtl/nfa_subset_construction_unit.sv
// nfa to dfa subset construction unit, top level; uses nsc_pkg and nsc_chain
// load beat: writes one table entry, no result. run beat: per dfa state a fetch
// state, then per symbol gather states over the nfa states and a search state;
// then a read and an emit state per emitted row. the transition gather loop
// sets the run time. synchronous active-low reset clears the transition table
// (valid bits), registers and control; the receiver cannot stall result beats.
module nfa_subset_construction_unit #(
    parameter int NFA_MAX = nsc_pkg::NFA_STATES_MAX,
    parameter int SYM_MAX = nsc_pkg::SYMBOLS_MAX,
    parameter int DFA_MAX = nsc_pkg::DFA_STATES_MAX
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    input  logic                       i_command,
    input  logic [nsc_pkg::SRC_W-1:0]  i_source_state,
    input  logic [nsc_pkg::SYM_W-1:0]  i_input_symbol,
    input  logic [nsc_pkg::MASK_W-1:0] i_target_mask,
    output logic                       o_strobe,
    output logic [nsc_pkg::IDX_W-1:0]  o_dfa_index,
    output logic [nsc_pkg::MASK_W-1:0] o_subset_mask,
    output logic                       o_accepting,
    output logic [nsc_pkg::IDX_W-1:0]  o_next_on_zero,
    output logic [nsc_pkg::IDX_W-1:0]  o_next_on_one,
    output logic [nsc_pkg::IDX_W-1:0]  o_next_on_two,
    output logic [nsc_pkg::IDX_W-1:0]  o_next_on_three,
    output logic                       o_last_row,
    output logic                       o_overflow
);
    import nsc_pkg::*;

    localparam int TT_D  = NFA_MAX * SYM_MAX;
    localparam int TA_W  = $clog2(TT_D);
    localparam int Q_W   = $clog2(NFA_MAX + 1);
    localparam int QI_W  = $clog2(NFA_MAX);
    localparam int POS_W = $clog2(DFA_MAX);
    localparam int DC_W  = $clog2(DFA_MAX + 1);
    localparam int SC_W  = $clog2(SYM_MAX + 1);
    localparam int SI_W  = (SYM_MAX > 1) ? $clog2(SYM_MAX) : 1;

    // memories
    logic [MASK_W-1:0] r_tt [TT_D];
    logic [TT_D-1:0]   r_tt_vld;
    logic [MASK_W-1:0] r_sub [DFA_MAX];
    logic [IDX_W-1:0]  r_nxt [DFA_MAX][SYM_MAX];

    logic [4:0]        r_nfa_cnt;
    logic [2:0]        r_sym_cnt;
    logic [MASK_W-1:0] r_accept;

    t_state r_state, n_state;

    logic [DC_W-1:0]   r_count;
    logic [DC_W-1:0]   r_cur;
    logic [SC_W-1:0]   r_sym;
    logic [Q_W-1:0]    r_q;
    logic [MASK_W-1:0] r_from, r_to, r_tt_rd, r_sub_rd;
    logic              r_tt_rd_ok;
    logic              r_ovf;
    logic [DC_W-1:0]   r_ovf_cur;
    logic [IDX_W-1:0]  r_nrd [SYM_MAX];

    logic [Q_W-1:0]    w_n;
    logic [SC_W-1:0]   w_syms;
    logic [MASK_W-1:0] w_live, w_key, w_new;
    t_chain_ctl        w_ctl;
    logic              w_hit;
    logic              w_seed;
    logic [POS_W-1:0]  w_pos;
    logic              w_load, w_run;
    logic [TA_W-1:0]   w_ld_addr, w_rd_addr;
    logic [IDX_W-1:0]  w_nxt [4];

    // clamped register values
    always_comb begin
        if (r_nfa_cnt == 5'd0) w_n = Q_W'(1);
        else if (32'(r_nfa_cnt) > NFA_MAX) w_n = Q_W'(NFA_MAX);
        else w_n = Q_W'(r_nfa_cnt);
        if (r_sym_cnt == 3'd0) w_syms = SC_W'(1);
        else if (32'(r_sym_cnt) > SYM_MAX) w_syms = SC_W'(SYM_MAX);
        else w_syms = SC_W'(r_sym_cnt);
        w_live = '0;
        for (int k = 0; k < MASK_W; k++) begin
            if (k < 32'(w_n)) w_live[k] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfa_cnt <= 5'd1;
            r_sym_cnt <= 3'd2;
            r_accept  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NFA_STATES: r_nfa_cnt <= i_cfg_data[4:0];
                REG_SYMBOLS:    r_sym_cnt <= i_cfg_data[2:0];
                REG_ACCEPT:     r_accept  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_load = start && !busy && (i_command == CMD_LOAD)
                    && (32'(i_source_state) < NFA_MAX) && (32'(i_input_symbol) < SYM_MAX);
    assign w_run  = start && !busy && (i_command == CMD_RUN);
    assign w_ld_addr = TA_W'(32'(i_source_state) * SYM_MAX + 32'(i_input_symbol));
    assign w_rd_addr = TA_W'(32'(r_q[QI_W-1:0]) * SYM_MAX + 32'(r_sym[SI_W-1:0]));

    // transition table: valid bits give the all-zero reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tt_vld <= '0;
        end else if (w_load) begin
            r_tt_vld[w_ld_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_tt[w_ld_addr] <= i_target_mask;
        r_tt_rd    <= r_tt[w_rd_addr];
        r_tt_rd_ok <= r_tt_vld[w_rd_addr] && r_from[r_q[QI_W-1:0]];
    end

    // first fetch of a run pushes the start subset into the chain
    assign w_seed = (r_state == ST_FETCH) && (r_cur == '0);
    assign w_key = r_to & w_live;
    assign w_new = w_seed ? MASK_W'(1) : w_key;
    assign w_ctl.clear = w_run;
    assign w_ctl.shift = w_seed
                         || ((r_state == ST_SEARCH) && !w_hit && (32'(r_count) < DFA_MAX));
    assign w_ctl.key   = w_key;

    nsc_chain #(.DFA_MAX(DFA_MAX)) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_new_mask (w_new),
        .o_hit      (w_hit),
        .o_hit_pos  (w_pos)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_run) n_state = ST_FETCH;
            ST_FETCH:  n_state = ST_GATHER;
            ST_GATHER: if (r_q == w_n) n_state = ST_SEARCH;
            ST_SEARCH: begin
                if (!w_hit && 32'(r_count) >= DFA_MAX) n_state = ST_EMIT_RD;
                else if (r_sym + 1'b1 < w_syms) n_state = ST_GATHER;
                else if (r_cur + 1'b1 < r_count + DC_W'(!w_hit)) n_state = ST_FETCH;
                else n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: n_state = ST_EMIT;
            ST_EMIT:    n_state = (r_cur + 1'b1 == r_count) ? ST_IDLE : ST_EMIT_RD;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cur     <= '0;
            r_sym     <= '0;
            r_q       <= '0;
            r_ovf     <= 1'b0;
            r_ovf_cur <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (w_run) begin
                    r_count <= DC_W'(1);
                    r_cur   <= '0;
                    r_ovf   <= 1'b0;
                end
                ST_FETCH: begin
                    r_sym <= '0;
                    r_q   <= '0;
                    r_to  <= '0;
                end
                ST_GATHER: begin
                    // one table read per cycle; the read data is registered before it is or-ed in
                    if (r_q != w_n) r_q <= r_q + 1'b1;
                    if (r_q != '0 && r_tt_rd_ok) r_to <= r_to | r_tt_rd;
                end
                ST_SEARCH: begin
                    r_q  <= '0;
                    r_to <= '0;
                    if (!w_hit && 32'(r_count) >= DFA_MAX) begin
                        r_ovf     <= 1'b1;
                        r_ovf_cur <= r_cur;
                        r_cur     <= '0;
                    end else begin
                        if (!w_hit) r_count <= r_count + 1'b1;
                        if (r_sym + 1'b1 < w_syms) r_sym <= r_sym + 1'b1;
                        else if (r_cur + 1'b1 < r_count + DC_W'(!w_hit))
                            r_cur <= r_cur + 1'b1;
                        else r_cur <= '0;
                    end
                end
                ST_EMIT_RD: ;
                ST_EMIT: r_cur <= (r_cur + 1'b1 == r_count) ? '0 : r_cur + 1'b1;
                default: ;
            endcase
        end
    end

    // subset and next-index stores
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_run) begin
            r_sub[0] <= MASK_W'(1);
        end else if (r_state == ST_SEARCH) begin
            if (!w_hit && 32'(r_count) < DFA_MAX) begin
                r_sub[r_count[POS_W-1:0]] <= w_key;
                r_nxt[r_cur[POS_W-1:0]][r_sym[SI_W-1:0]] <= IDX_W'(r_count);
            end else if (w_hit) begin
                r_nxt[r_cur[POS_W-1:0]][r_sym[SI_W-1:0]] <=
                    IDX_W'(r_count - 1'b1 - DC_W'(w_pos));
            end
        end
        r_sub_rd <= r_sub[r_cur[POS_W-1:0]];
        for (int s = 0; s < SYM_MAX; s++) r_nrd[s] <= r_nxt[r_cur[POS_W-1:0]][s];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FETCH) r_from <= r_sub[r_cur[POS_W-1:0]];
    end

    // outputs
    always_comb begin
        // entries past the overflow point or for unused symbols read zero
        for (int s = 0; s < 4; s++) w_nxt[s] = '0;
        for (int s = 0; s < SYM_MAX; s++) begin
            if (32'(s) < 32'(w_syms) && (!r_ovf || r_cur < r_ovf_cur
                    || (r_cur == r_ovf_cur && 32'(s) < 32'(r_sym))))
                w_nxt[s] = r_nrd[s];
        end
        busy            = (r_state != ST_IDLE);
        o_strobe        = (r_state == ST_EMIT);
        o_dfa_index     = IDX_W'(r_cur);
        o_subset_mask   = r_sub_rd;
        o_accepting     = |(r_sub_rd & r_accept);
        o_next_on_zero  = w_nxt[0];
        o_next_on_one   = w_nxt[1];
        o_next_on_two   = w_nxt[2];
        o_next_on_three = w_nxt[3];
        o_last_row      = (r_cur + 1'b1 == r_count);
        o_overflow      = r_ovf;
    end
endmodule

// File: dv/tb.sv
// self-checking testbench for nfa_subset_construction_unit
// depends on rtl/nsc_pkg.sv and the rtl top level; predicts each table row in place
`timescale 1ns / 1ps

module tb;
    import nsc_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [MASK_W-1:0] subset;
        logic              acc;
        logic [IDX_W-1:0]  nx0;
        logic [IDX_W-1:0]  nx1;
        logic [IDX_W-1:0]  nx2;
        logic [IDX_W-1:0]  nx3;
        logic              last;
        logic              ovf;
    } t_row;

    typedef struct packed {
        logic              cmd;
        logic [SRC_W-1:0]  src;
        logic [SYM_W-1:0]  sym;
        logic [MASK_W-1:0] mask;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic i_command = 1'b0;
    logic [SRC_W-1:0] i_source_state = '0;
    logic [SYM_W-1:0] i_input_symbol = '0;
    logic [MASK_W-1:0] i_target_mask = '0;
    logic o_strobe, o_accepting, o_last_row, o_overflow;
    logic [IDX_W-1:0] o_dfa_index, o_next_on_zero, o_next_on_one, o_next_on_two;
    logic [IDX_W-1:0] o_next_on_three;
    logic [MASK_W-1:0] o_subset_mask;

    nfa_subset_construction_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // shadow of the block
    logic [MASK_W-1:0] nfa_edges [NFA_STATES_MAX][SYMBOLS_MAX];
    logic [4:0]  cfg_states = 5'd1;
    logic [2:0]  cfg_symbols = 3'd2;
    logic [15:0] cfg_accept = 16'd0;

    t_row pending_rows[$];
    int   fail_count = 0;
    int   rows_seen = 0;
    int   beats_sent = 0;
    int   runs_sent = 0;
    int   overflow_runs = 0;
    int   idle_pct = 0;

    // breadth-first subset construction, rows pushed in index order
    task automatic build_table_rows();
        int n, s, cnt, hit;
        logic [MASK_W-1:0] live, to;
        logic [MASK_W-1:0] subs [DFA_STATES_MAX];
        logic [IDX_W-1:0]  nxt [DFA_STATES_MAX][SYMBOLS_MAX];
        bit full;
        t_row r;
        n = (cfg_states < 1) ? 1 : (cfg_states > NFA_STATES_MAX) ? NFA_STATES_MAX : cfg_states;
        s = (cfg_symbols < 1) ? 1 : (cfg_symbols > SYMBOLS_MAX) ? SYMBOLS_MAX : cfg_symbols;
        live = (n >= 16) ? 16'hFFFF : 16'((1 << n) - 1);
        foreach (nxt[i, j]) nxt[i][j] = '0;
        subs[0] = 16'h0001;
        cnt = 1;
        full = 0;
        for (int cur = 0; cur < cnt && !full; cur++) begin
            for (int sy = 0; sy < s && !full; sy++) begin
                to = '0;
                for (int q = 0; q < n; q++)
                    if (subs[cur][q]) to |= nfa_edges[q][sy];
                to &= live;
                hit = -1;
                for (int k = 0; k < cnt; k++)
                    if (hit < 0 && subs[k] == to) hit = k;
                if (hit >= 0) nxt[cur][sy] = IDX_W'(hit);
                else if (cnt >= DFA_STATES_MAX) full = 1;
                else begin
                    subs[cnt] = to;
                    nxt[cur][sy] = IDX_W'(cnt);
                    cnt++;
                end
            end
        end
        if (full) overflow_runs++;
        for (int i = 0; i < cnt; i++) begin
            r.idx = IDX_W'(i);
            r.subset = subs[i];
            r.acc = |(subs[i] & cfg_accept);
            r.nx0 = nxt[i][0];
            r.nx1 = nxt[i][1];
            r.nx2 = nxt[i][2];
            r.nx3 = nxt[i][3];
            r.last = (i + 1 == cnt);
            r.ovf = full;
            pending_rows.push_back(r);
        end
    endtask

    // drive one beat, hold until accepted, then maybe leave a gap
    task automatic send_beat(t_beat b, bit typed_reset_run);
        start <= 1'b1;
        i_command <= b.cmd;
        i_source_state <= b.src;
        i_input_symbol <= b.sym;
        i_target_mask <= b.mask;
        do @(posedge i_clk); while (busy);
        beats_sent++;
        if (b.cmd == CMD_LOAD) nfa_edges[b.src][b.sym] = b.mask;
        else begin
            runs_sent++;
            if (typed_reset_run) begin
                // empty table, one state, two symbols: {0} and the empty set
                pending_rows.push_back('{0, 16'h0001, 0, 1, 1, 0, 0, 0, 0});
                pending_rows.push_back('{1, 16'h0000, 0, 1, 1, 0, 0, 1, 0});
            end else build_table_rows();
        end
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rows.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_NFA_STATES: cfg_states = val[4:0];
            REG_SYMBOLS:    cfg_symbols = val[2:0];
            REG_ACCEPT:     cfg_accept = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [15:0] n, logic [15:0] s, logic [15:0] a);
        drain();
        write_reg(REG_NFA_STATES, n);
        write_reg(REG_SYMBOLS, s);
        write_reg(REG_ACCEPT, a);
    endtask

    always @(posedge i_clk) begin
        t_row got, want;
        if (i_rst_n && o_strobe) begin
            got = '{o_dfa_index, o_subset_mask, o_accepting, o_next_on_zero, o_next_on_one,
                    o_next_on_two, o_next_on_three, o_last_row, o_overflow};
            rows_seen++;
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected row %p", $time, got);
                fail_count++;
            end else begin
                want = pending_rows.pop_front();
                if (got !== want) begin
                    $display("%0t: row mismatch expected %p actual %p", $time, want, got);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    t_beat directed [7] = '{
        '{CMD_RUN,  4'd0,  2'd0, 16'h0000},
        '{CMD_LOAD, 4'd15, 2'd3, 16'hFFFF},
        '{CMD_LOAD, 4'd0,  2'd0, 16'h0002},
        '{CMD_LOAD, 4'd1,  2'd1, 16'hFFFF},
        '{CMD_LOAD, 4'd0,  2'd3, 16'h8000},
        '{CMD_LOAD, 4'd0,  2'd1, 16'h0000},
        '{CMD_RUN,  4'd0,  2'd0, 16'h0000}
    };

    initial begin
        t_beat b;
        int nloads;
        foreach (nfa_edges[i, j]) nfa_edges[i][j] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config first, then clamp extremes and the spare index
        foreach (directed[k]) send_beat(directed[k], k == 0);
        set_config(16'd31, 16'd7, 16'hFFFF);
        send_beat('{CMD_RUN, 4'd0, 2'd0, 16'h0}, 0);
        set_config(16'd0, 16'd0, 16'h0001);
        write_reg(REG_SPARE, 16'hAAAA);
        send_beat('{CMD_RUN, 4'd0, 2'd0, 16'h0}, 0);
        set_config(16'd16, 16'd4, 16'h5555);
        send_beat('{CMD_LOAD, 4'd2, 2'd2, 16'hFFFF}, 0);
        send_beat('{CMD_LOAD, 4'd0, 2'd2, 16'h0004}, 0);
        send_beat('{CMD_RUN, 4'd0, 2'd0, 16'h0}, 0);

        // random: sequences of loads, mostly closed by a run, three idling regimes
        while (beats_sent < 220) begin
            idle_pct = (beats_sent < 90) ? 38 : (beats_sent < 160) ? 71 : 0;
            if ($urandom_range(3) == 0)
                set_config(16'($urandom_range(31)), 16'($urandom_range(7)), 16'($urandom));
            else
                set_config(16'($urandom_range(16, 1)), 16'($urandom_range(4, 1)),
                           16'($urandom));
            nloads = $urandom_range(14, 2);
            for (int k = 0; k < nloads; k++) begin
                b.cmd = CMD_LOAD;
                b.src = SRC_W'($urandom);
                b.sym = SYM_W'($urandom);
                b.mask = ($urandom_range(2) == 0) ? 16'($urandom)
                                                   : 16'($urandom & $urandom & $urandom);
                send_beat(b, 0);
            end
            b = '{CMD_RUN, 4'($urandom), 2'($urandom), 16'($urandom)};
            if ($urandom_range(5) != 0) send_beat(b, 0);
            if ($urandom_range(7) == 0) send_beat(b, 0);
            if (beats_sent > 120 && beats_sent < 140) begin
                // hold off until the table is fully out
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_rows.size() != 0) @(posedge i_clk);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("covered %0d beats, %0d runs, %0d rows, %0d runs overflowed",
                 beats_sent, runs_sent, rows_seen, overflow_runs);
        if (fail_count == 0 && pending_rows.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
